// ===== rtl/gmrs_pkg.sv =====
// shared types, constants and helpers of the gradient max ratio scaler
`default_nettype none
package gmrs_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int FRAC_BITS    = 16;
    localparam int FACTOR_W     = 48;
    localparam int SPLIT        = 24;
    localparam int PROD_W       = SAMPLE_WIDTH + SPLIT;
    localparam int FULL_W       = SAMPLE_WIDTH + FACTOR_W;
    localparam int RAD_W        = 2 * SAMPLE_WIDTH + 2;
    localparam int DVD_W        = SAMPLE_WIDTH + FRAC_BITS;

    localparam logic [1:0] FUNC_ACC = 2'd0;
    localparam logic [1:0] FUNC_FIN = 2'd1;
    localparam logic [1:0] FUNC_SCL = 2'd2;

    localparam logic [FACTOR_W-1:0] FACTOR_SAT = {FACTOR_W{1'b1}};
    localparam logic [FACTOR_W-1:0] POS_SAT    = {1'b0, {(FACTOR_W-1){1'b1}}};
    localparam logic [FACTOR_W-1:0] NEG_SAT    = {1'b1, {(FACTOR_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_ACC,
        OP_FIN,
        OP_SCL
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AMUL,
        ST_SQRT,
        ST_DSTART,
        ST_DIV,
        ST_SMUL,
        ST_SOUT
    } t_state;

    typedef struct packed {
        t_op                      op;
        logic [SAMPLE_WIDTH-1:0]  p;
        logic [SAMPLE_WIDTH-1:0]  s;
        logic [SAMPLE_WIDTH-1:0]  rho;
        logic [SAMPLE_WIDTH-1:0]  gp;
        logic [SAMPLE_WIDTH-1:0]  gs;
        logic [SAMPLE_WIDTH-1:0]  gr;
    } t_cmd;

    function automatic logic [SAMPLE_WIDTH-1:0] mag_of(input logic [SAMPLE_WIDTH-1:0] v);
        return v[SAMPLE_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gmrs_front.sv =====
// front end: accepts items, drops unused commands, queues the rest
`default_nettype none
module gmrs_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [1:0]                   i_func,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0] i_p_modulus,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0] i_shear_modulus,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0] i_density,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0] i_grad_p,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0] i_grad_s,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0] i_grad_rho,
    output logic                              o_cmd_valid,
    output gmrs_pkg::t_cmd                    o_cmd,
    input  wire logic                         i_cmd_take
);
    import gmrs_pkg::*;

    t_cmd       r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;
    logic       acc, push, known;
    t_cmd       in_cmd;

    always_comb begin
        known     = 1'b1;
        in_cmd.op = OP_ACC;
        case (i_func)
            FUNC_ACC: in_cmd.op = OP_ACC;
            FUNC_FIN: in_cmd.op = OP_FIN;
            FUNC_SCL: in_cmd.op = OP_SCL;
            default:  known = 1'b0;
        endcase
        in_cmd.p   = i_p_modulus;
        in_cmd.s   = i_shear_modulus;
        in_cmd.rho = i_density;
        in_cmd.gp  = i_grad_p;
        in_cmd.gs  = i_grad_s;
        in_cmd.gr  = i_grad_rho;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign acc         = i_valid && !o_stall;
    assign push        = acc && known;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_cmd_take) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_cmd_take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_take) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gmrs_sqrt.sv =====
// bit-serial integer square root, saturating above the sample range
`default_nettype none
module gmrs_sqrt (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [gmrs_pkg::RAD_W-1:0]        i_rad,
    output logic                                   o_busy,
    output logic [gmrs_pkg::SAMPLE_WIDTH-1:0]      o_root
);
    import gmrs_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    logic [2*SW-1:0] r_rad;
    logic [SW+1:0]   r_rem;
    logic [SW-1:0]   r_root;
    logic [$clog2(SW)-1:0] r_cnt;
    logic            r_busy, r_sat;
    logic [SW+3:0]   rem2;
    logic [SW+3:0]   trial;
    logic            ge;

    assign rem2  = {r_rem, r_rad[2*SW-1 -: 2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == {$clog2(SW){1'b1}})) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= |i_rad[RAD_W-1:2*SW];
            r_rad  <= i_rad[2*SW-1:0];
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[2*SW-3:0], 2'b00};
            r_cnt <= r_cnt + 1'b1;
            if (ge) begin
                r_rem  <= (SW+2)'(rem2 - trial);
                r_root <= {r_root[SW-2:0], 1'b1};
            end else begin
                r_rem  <= rem2[SW+1:0];
                r_root <= {r_root[SW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_sat ? {SW{1'b1}} : r_root;

endmodule
`default_nettype wire

// ===== rtl/gmrs_div.sv =====
// restoring divider for one scale factor, one quotient bit per cycle
`default_nettype none
module gmrs_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0] i_num,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0] i_den,
    output logic                                   o_busy,
    output logic                                   o_zero,
    output logic [gmrs_pkg::FACTOR_W-1:0]          o_quo
);
    import gmrs_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    logic [DVD_W-1:0]         r_dvd;
    logic [SW-1:0]            r_rem, r_den;
    logic [$clog2(DVD_W)-1:0] r_cnt;
    logic                     r_busy;
    logic [SW:0]              rem2;
    logic                     ge;

    assign rem2 = {r_rem, r_dvd[DVD_W-1]};
    assign ge   = (rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == ($clog2(DVD_W))'(DVD_W - 1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_num, {FRAC_BITS{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
            r_rem <= ge ? SW'(rem2 - {1'b0, r_den}) : rem2[SW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_zero = (r_den == '0);
    assign o_quo  = o_zero ? FACTOR_SAT : FACTOR_W'(r_dvd);

endmodule
`default_nettype wire

// ===== rtl/gmrs_back.sv =====
// back end: maxima, factor and scaling datapath with the result register
`default_nettype none
module gmrs_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  wire gmrs_pkg::t_cmd                i_cmd,
    output logic                               o_cmd_take,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [gmrs_pkg::FACTOR_W-1:0]      o_scaled_p,
    output logic [gmrs_pkg::FACTOR_W-1:0]      o_scaled_s,
    output logic [gmrs_pkg::FACTOR_W-1:0]      o_scaled_rho,
    output logic [gmrs_pkg::FACTOR_W-1:0]      o_factor_p,
    output logic [gmrs_pkg::FACTOR_W-1:0]      o_factor_s,
    output logic [gmrs_pkg::FACTOR_W-1:0]      o_factor_rho,
    output logic [2:0]                         o_zero_flags
);
    import gmrs_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int FW = FACTOR_W;

    t_state r_state, n_state;
    t_cmd   r_cmd;

    logic [SW-1:0] r_max_zp, r_max_zs, r_max_rho, r_max_gp, r_max_gs, r_max_gr;
    logic [FW-1:0] r_scale [3];
    logic [PROD_W-1:0] r_pa [3];
    logic [PROD_W-1:0] r_pb [3];
    logic [2:0]        r_neg;

    logic          r_ovalid;
    logic [FW-1:0] r_osc [3];
    logic [FW-1:0] r_ofc [3];
    logic [2:0]    r_ozf;

    logic          out_free, sq_start, dv_start, acc_upd, fin_done, scl_done;
    logic [1:0]    sq_busy;
    logic [2:0]    dv_busy, dv_zero;
    logic [SW-1:0] root_p, root_s;
    logic [FW-1:0] quo [3];
    logic [RAD_W-1:0] rad_p, rad_s;
    logic [SW-1:0] grad [3];
    logic [SW-1:0] mag  [3];
    logic [FW-1:0] clamped [3];

    function automatic logic [FW-1:0] clamp_scaled(
        input logic [PROD_W-1:0] a,
        input logic [PROD_W-1:0] b,
        input logic              neg
    );
        logic [FULL_W-1:0] full;
        logic [FULL_W-1:0] q;
        logic [FW-1:0]     m;
        full = {a, {SPLIT{1'b0}}} + FULL_W'(b);
        q    = full >> FRAC_BITS;
        if (neg) begin
            m = (q > FULL_W'(NEG_SAT)) ? NEG_SAT : q[FW-1:0];
            return ~m + 1'b1;
        end
        return (q > FULL_W'(POS_SAT)) ? POS_SAT : q[FW-1:0];
    endfunction

    assign out_free = !r_ovalid || !i_stall;
    assign rad_p = RAD_W'({2'b00, r_cmd.p} + {1'b0, r_cmd.s, 1'b0}) * RAD_W'(r_cmd.rho);
    assign rad_s = RAD_W'(r_cmd.s) * RAD_W'(r_cmd.rho);
    assign grad[0] = r_cmd.gp;
    assign grad[1] = r_cmd.gs;
    assign grad[2] = r_cmd.gr;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i]     = mag_of(grad[i]);
            clamped[i] = clamp_scaled(r_pa[i], r_pb[i], r_neg[i]);
        end
    end

    gmrs_sqrt u_sqrt_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_rad(rad_p),
        .o_busy(sq_busy[0]), .o_root(root_p)
    );
    gmrs_sqrt u_sqrt_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_rad(rad_s),
        .o_busy(sq_busy[1]), .o_root(root_s)
    );
    gmrs_div u_div_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start), .i_num(r_max_zp),
        .i_den(r_max_gp), .o_busy(dv_busy[0]), .o_zero(dv_zero[0]), .o_quo(quo[0])
    );
    gmrs_div u_div_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start), .i_num(r_max_zs),
        .i_den(r_max_gs), .o_busy(dv_busy[1]), .o_zero(dv_zero[1]), .o_quo(quo[1])
    );
    gmrs_div u_div_rho (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start), .i_num(r_max_rho),
        .i_den(r_max_gr), .o_busy(dv_busy[2]), .o_zero(dv_zero[2]), .o_quo(quo[2])
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_ACC:  n_state = ST_AMUL;
                        OP_FIN:  n_state = ST_DSTART;
                        OP_SCL:  n_state = ST_SMUL;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_AMUL:   n_state = ST_SQRT;
            ST_SQRT:   if (sq_busy == 2'b00) n_state = ST_IDLE;
            ST_DSTART: n_state = ST_DIV;
            ST_DIV:    if ((dv_busy == 3'b000) && out_free) n_state = ST_IDLE;
            ST_SMUL:   n_state = ST_SOUT;
            ST_SOUT:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_take = 1'b0;
        sq_start   = 1'b0;
        dv_start   = 1'b0;
        acc_upd    = 1'b0;
        fin_done   = 1'b0;
        scl_done   = 1'b0;
        case (r_state)
            ST_IDLE:   o_cmd_take = i_cmd_valid;
            ST_AMUL:   sq_start = 1'b1;
            ST_SQRT:   acc_upd = (sq_busy == 2'b00);
            ST_DSTART: dv_start = 1'b1;
            ST_DIV:    fin_done = (dv_busy == 3'b000) && out_free;
            ST_SOUT:   scl_done = out_free;
            default:   o_cmd_take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_max_zp  <= '0;
            r_max_zs  <= '0;
            r_max_rho <= '0;
            r_max_gp  <= '0;
            r_max_gs  <= '0;
            r_max_gr  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_scale[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (fin_done || scl_done) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (acc_upd) begin
                if (root_p > r_max_zp)    r_max_zp  <= root_p;
                if (root_s > r_max_zs)    r_max_zs  <= root_s;
                if (r_cmd.rho > r_max_rho) r_max_rho <= r_cmd.rho;
                if (mag[0] > r_max_gp)    r_max_gp  <= mag[0];
                if (mag[1] > r_max_gs)    r_max_gs  <= mag[1];
                if (mag[2] > r_max_gr)    r_max_gr  <= mag[2];
            end
            if (fin_done) begin
                r_max_zp  <= '0;
                r_max_zs  <= '0;
                r_max_rho <= '0;
                r_max_gp  <= '0;
                r_max_gs  <= '0;
                r_max_gr  <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_scale[i] <= quo[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_SMUL) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i]  <= mag[i] * r_scale[i][FW-1:SPLIT];
                r_pb[i]  <= mag[i] * r_scale[i][SPLIT-1:0];
                r_neg[i] <= grad[i][SW-1];
            end
        end
        if (fin_done) begin
            for (int i = 0; i < 3; i++) begin
                r_osc[i] <= '0;
                r_ofc[i] <= quo[i];
            end
            r_ozf <= dv_zero;
        end else if (scl_done) begin
            for (int i = 0; i < 3; i++) begin
                r_osc[i] <= clamped[i];
                r_ofc[i] <= r_scale[i];
            end
            r_ozf <= 3'b000;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_scaled_p   = r_osc[0];
    assign o_scaled_s   = r_osc[1];
    assign o_scaled_rho = r_osc[2];
    assign o_factor_p   = r_ofc[0];
    assign o_factor_s   = r_ofc[1];
    assign o_factor_rho = r_ofc[2];
    assign o_zero_flags = r_ozf;

    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT && sq_busy == 2'b00) |=> (r_state == ST_IDLE))
        else $error("accumulate did not retire after the roots settled");

    a_fin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_done |=> (r_max_zp == '0 && r_max_gp == '0 && r_max_rho == '0))
        else $error("maxima not cleared by finalize");

    a_flag_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ozf[0]) |-> (r_ofc[0] == FACTOR_SAT))
        else $error("zero flag without a saturated factor");

endmodule
`default_nettype wire

// ===== rtl/gradient_max_ratio_scaler_unit.sv =====
// top level of the gradient max ratio scaler
// Takes one item at a time through a two-entry command queue; a result sits in
// an output register while the next item is already accepted. Accumulate forms
// one 34x32 product, then runs the bit-serial root units; finalize runs the
// restoring dividers and scale forms split partial products, then truncates
// and clamps them. func 3 is dropped at the input with no result. Factors and
// maxima clear at reset.
`default_nettype none
module gradient_max_ratio_scaler_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [1:0]                            i_func,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0]     i_p_modulus,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0]     i_shear_modulus,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0]     i_density,
    input  wire logic signed [gmrs_pkg::SAMPLE_WIDTH-1:0] i_grad_p,
    input  wire logic signed [gmrs_pkg::SAMPLE_WIDTH-1:0] i_grad_s,
    input  wire logic signed [gmrs_pkg::SAMPLE_WIDTH-1:0] i_grad_rho,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [gmrs_pkg::FACTOR_W-1:0]       o_scaled_p,
    output logic signed [gmrs_pkg::FACTOR_W-1:0]       o_scaled_s,
    output logic signed [gmrs_pkg::FACTOR_W-1:0]       o_scaled_rho,
    output logic [gmrs_pkg::FACTOR_W-1:0]              o_factor_p,
    output logic [gmrs_pkg::FACTOR_W-1:0]              o_factor_s,
    output logic [gmrs_pkg::FACTOR_W-1:0]              o_factor_rho,
    output logic [2:0]                                 o_zero_flags
);
    import gmrs_pkg::*;

    logic cmd_valid, cmd_take;
    t_cmd cmd;
    logic [FACTOR_W-1:0] sc_p, sc_s, sc_rho;

    gmrs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_p_modulus(i_p_modulus), .i_shear_modulus(i_shear_modulus),
        .i_density(i_density), .i_grad_p(i_grad_p), .i_grad_s(i_grad_s),
        .i_grad_rho(i_grad_rho), .o_cmd_valid(cmd_valid), .o_cmd(cmd),
        .i_cmd_take(cmd_take)
    );

    gmrs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .o_valid(o_valid), .i_stall(i_stall),
        .o_scaled_p(sc_p), .o_scaled_s(sc_s), .o_scaled_rho(sc_rho),
        .o_factor_p(o_factor_p), .o_factor_s(o_factor_s), .o_factor_rho(o_factor_rho),
        .o_zero_flags(o_zero_flags)
    );

    assign o_scaled_p   = sc_p;
    assign o_scaled_s   = sc_s;
    assign o_scaled_rho = sc_rho;

endmodule
`default_nettype wire

// ===== tb/gmrs_checker.sv =====
// checker for the gradient max ratio scaler: predicts results from observed transfers and compares
`default_nettype none
module gmrs_checker (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_in_valid,
    input  wire logic                                      i_in_stall,
    input  wire logic [1:0]                                i_func,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0]         i_p_modulus,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0]         i_shear_modulus,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0]         i_density,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0]         i_grad_p,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0]         i_grad_s,
    input  wire logic [gmrs_pkg::SAMPLE_WIDTH-1:0]         i_grad_rho,
    input  wire logic                                      i_out_valid,
    input  wire logic                                      i_out_stall,
    input  wire logic [gmrs_pkg::FACTOR_W-1:0]             i_scaled_p,
    input  wire logic [gmrs_pkg::FACTOR_W-1:0]             i_scaled_s,
    input  wire logic [gmrs_pkg::FACTOR_W-1:0]             i_scaled_rho,
    input  wire logic [gmrs_pkg::FACTOR_W-1:0]             i_factor_p,
    input  wire logic [gmrs_pkg::FACTOR_W-1:0]             i_factor_s,
    input  wire logic [gmrs_pkg::FACTOR_W-1:0]             i_factor_rho,
    input  wire logic [2:0]                                i_zero_flags,
    output int                                             o_fail_count,
    output int                                             o_pending
);
    import gmrs_pkg::*;

    localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
    localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] POS47 = 64'h7FFF_FFFF_FFFF;
    localparam logic [63:0] NEG47 = 64'h8000_0000_0000;

    typedef struct {
        logic [FACTOR_W-1:0] scaled_p;
        logic [FACTOR_W-1:0] scaled_s;
        logic [FACTOR_W-1:0] scaled_rho;
        logic [FACTOR_W-1:0] factor_p;
        logic [FACTOR_W-1:0] factor_s;
        logic [FACTOR_W-1:0] factor_rho;
        logic [2:0]          zero_flags;
    } t_scaler_result;

    t_scaler_result result_q[$];

    logic [63:0] peak_zp, peak_zs, peak_rho, peak_gp, peak_gs, peak_gr;
    logic [63:0] fac_p, fac_s, fac_rho;
    int          mismatches;

    function automatic logic [63:0] magnitude(input logic [SAMPLE_WIDTH-1:0] v);
        logic [63:0] m;
        m = {32'd0, v};
        if (v[SAMPLE_WIDTH-1])
            m = (64'd1 << SAMPLE_WIDTH) - m;
        return m;
    endfunction

    function automatic logic [63:0] impedance(input logic [63:0] a, input logic [63:0] b);
        logic [131:0] x, r, bt;
        x  = a * b;
        r  = 0;
        bt = 132'd1 << 130;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return (r > MAX32) ? MAX32 : r[63:0];
    endfunction

    function automatic logic [63:0] ratio(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        if (den == 0)
            return MAX48;
        q = (num << FRAC_BITS) / den;
        return (q > MAX48) ? MAX48 : q;
    endfunction

    function automatic logic [FACTOR_W-1:0] apply_factor(input logic [SAMPLE_WIDTH-1:0] g,
                                                         input logic [63:0] f);
        logic [63:0] mag, hi, lo, q;
        mag = magnitude(g);
        hi  = mag * (f >> 24);
        lo  = mag * (f & 64'hFF_FFFF);
        if (hi >= (64'd1 << (24 + FRAC_BITS)))
            q = MAX48;
        else
            q = (hi << (24 - FRAC_BITS)) + (lo >> FRAC_BITS);
        if (g[SAMPLE_WIDTH-1]) begin
            if (q > NEG47)
                q = NEG47;
            q = (~q) + 64'd1;
            return q[FACTOR_W-1:0];
        end
        return (q > POS47) ? POS47[FACTOR_W-1:0] : q[FACTOR_W-1:0];
    endfunction

    assign o_fail_count = mismatches;
    assign o_pending    = result_q.size();

    always @(posedge i_clk) begin
        t_scaler_result exp_r;
        t_scaler_result got;
        logic [63:0]    zp, zs;
        bit             bad;
        if (!i_rst_n) begin
            peak_zp <= 0; peak_zs <= 0; peak_rho <= 0;
            peak_gp <= 0; peak_gs <= 0; peak_gr <= 0;
            fac_p <= 0; fac_s <= 0; fac_rho <= 0;
            mismatches <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.scaled_p   = i_scaled_p;
                got.scaled_s   = i_scaled_s;
                got.scaled_rho = i_scaled_rho;
                got.factor_p   = i_factor_p;
                got.factor_s   = i_factor_s;
                got.factor_rho = i_factor_rho;
                got.zero_flags = i_zero_flags;
                if (result_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("ERROR: unexpected result transfer at %0t", $time);
                    mismatches <= mismatches + 1;
                end else begin
                    exp_r = result_q.pop_front();
                    bad = (exp_r.scaled_p !== got.scaled_p) || (exp_r.scaled_s !== got.scaled_s)
                       || (exp_r.scaled_rho !== got.scaled_rho)
                       || (exp_r.factor_p !== got.factor_p) || (exp_r.factor_s !== got.factor_s)
                       || (exp_r.factor_rho !== got.factor_rho)
                       || (exp_r.zero_flags !== got.zero_flags);
                    if (bad) begin
                        if (mismatches < 10) begin
                            $display("ERROR: result mismatch at %0t", $time);
                            $display("  expected scaled %h %h %h factor %h %h %h flags %b",
                                     exp_r.scaled_p, exp_r.scaled_s, exp_r.scaled_rho,
                                     exp_r.factor_p, exp_r.factor_s, exp_r.factor_rho,
                                     exp_r.zero_flags);
                            $display("  actual   scaled %h %h %h factor %h %h %h flags %b",
                                     got.scaled_p, got.scaled_s, got.scaled_rho,
                                     got.factor_p, got.factor_s, got.factor_rho,
                                     got.zero_flags);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_func)
                    FUNC_ACC: begin
                        zp = impedance({32'd0, i_p_modulus} + 2 * {32'd0, i_shear_modulus},
                                       {32'd0, i_density});
                        zs = impedance({32'd0, i_shear_modulus}, {32'd0, i_density});
                        if (zp > peak_zp) peak_zp <= zp;
                        if (zs > peak_zs) peak_zs <= zs;
                        if ({32'd0, i_density} > peak_rho) peak_rho <= {32'd0, i_density};
                        if (magnitude(i_grad_p) > peak_gp) peak_gp <= magnitude(i_grad_p);
                        if (magnitude(i_grad_s) > peak_gs) peak_gs <= magnitude(i_grad_s);
                        if (magnitude(i_grad_rho) > peak_gr) peak_gr <= magnitude(i_grad_rho);
                    end
                    FUNC_FIN: begin
                        exp_r.scaled_p   = 0;
                        exp_r.scaled_s   = 0;
                        exp_r.scaled_rho = 0;
                        exp_r.factor_p   = ratio(peak_zp, peak_gp);
                        exp_r.factor_s   = ratio(peak_zs, peak_gs);
                        exp_r.factor_rho = ratio(peak_rho, peak_gr);
                        exp_r.zero_flags = {peak_gr == 0, peak_gs == 0, peak_gp == 0};
                        fac_p   <= {16'd0, exp_r.factor_p};
                        fac_s   <= {16'd0, exp_r.factor_s};
                        fac_rho <= {16'd0, exp_r.factor_rho};
                        peak_zp <= 0; peak_zs <= 0; peak_rho <= 0;
                        peak_gp <= 0; peak_gs <= 0; peak_gr <= 0;
                        result_q.push_back(exp_r);
                    end
                    FUNC_SCL: begin
                        exp_r.scaled_p   = apply_factor(i_grad_p, fac_p);
                        exp_r.scaled_s   = apply_factor(i_grad_s, fac_s);
                        exp_r.scaled_rho = apply_factor(i_grad_rho, fac_rho);
                        exp_r.factor_p   = fac_p[FACTOR_W-1:0];
                        exp_r.factor_s   = fac_s[FACTOR_W-1:0];
                        exp_r.factor_rho = fac_rho[FACTOR_W-1:0];
                        exp_r.zero_flags = 0;
                        result_q.push_back(exp_r);
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench top of the gradient max ratio scaler: stimulus, idling, watchdog and verdict
`default_nettype none
module tb_top;
    import gmrs_pkg::*;

    localparam logic [1:0] FUNC_NOP   = 2'd3;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         POINTS     = 1700;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [1:0]               i_func = FUNC_NOP;
    logic [SAMPLE_WIDTH-1:0]  i_p_modulus = '0;
    logic [SAMPLE_WIDTH-1:0]  i_shear_modulus = '0;
    logic [SAMPLE_WIDTH-1:0]  i_density = '0;
    logic [SAMPLE_WIDTH-1:0]  i_grad_p = '0;
    logic [SAMPLE_WIDTH-1:0]  i_grad_s = '0;
    logic [SAMPLE_WIDTH-1:0]  i_grad_rho = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [FACTOR_W-1:0]      o_scaled_p, o_scaled_s, o_scaled_rho;
    logic [FACTOR_W-1:0]      o_factor_p, o_factor_s, o_factor_rho;
    logic [2:0]               o_zero_flags;
    int                       fail_count;
    int                       pending;
    int                       idle_cycles = 0;
    int                       points_sent = 0;
    bit                       busy_sender = 1'b0;
    bit                       busy_receiver = 1'b0;

    always #10 i_clk = ~i_clk;

    gradient_max_ratio_scaler_unit u_top (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_p_modulus, .i_shear_modulus,
        .i_density, .i_grad_p, .i_grad_s, .i_grad_rho, .o_valid, .i_stall,
        .o_scaled_p, .o_scaled_s, .o_scaled_rho, .o_factor_p, .o_factor_s, .o_factor_rho,
        .o_zero_flags
    );

    gmrs_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid(i_valid), .i_in_stall(o_stall), .i_func,
        .i_p_modulus, .i_shear_modulus, .i_density, .i_grad_p, .i_grad_s, .i_grad_rho,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_scaled_p(o_scaled_p),
        .i_scaled_s(o_scaled_s), .i_scaled_rho(o_scaled_rho), .i_factor_p(o_factor_p),
        .i_factor_s(o_factor_s), .i_factor_rho(o_factor_rho), .i_zero_flags(o_zero_flags),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int idle_length(input bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (busy || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 255);
            5: return -$urandom_range(1, 255);
            6: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // receiver backpressure
    always @(posedge i_clk) begin
        int hold;
        if (i_rst_n) begin
            if ($urandom_range(0, 199) == 0)
                busy_receiver <= ~busy_receiver;
            hold = idle_length(busy_receiver);
            i_stall <= (hold != 0) && ($urandom_range(0, hold) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_point(input logic [1:0] func, input logic [31:0] p,
                              input logic [31:0] s, input logic [31:0] rho,
                              input logic [31:0] gp, input logic [31:0] gs,
                              input logic [31:0] gr);
        int gap;
        gap = idle_length(busy_sender);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_func          <= func;
        i_p_modulus     <= p;
        i_shear_modulus <= s;
        i_density       <= rho;
        i_grad_p        <= gp;
        i_grad_s        <= gs;
        i_grad_rho      <= gr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (func != FUNC_NOP)
            points_sent++;
    endtask

    task automatic send_random(input logic [1:0] func);
        send_point(func, pick_value(), pick_value(), pick_value(),
                   pick_value(), pick_value(), pick_value());
    endtask

    initial begin
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // scale before any finalize, empty finalize
        send_point(FUNC_SCL, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_point(FUNC_FIN, 0, 0, 0, 0, 0, 0);
        // saturated impedance, extreme gradients
        send_point(FUNC_ACC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_point(FUNC_ACC, 0, 0, 0, 0, 0, 0);
        send_point(FUNC_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(FUNC_FIN, 0, 0, 0, 0, 0, 0);
        send_point(FUNC_SCL, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        // scaled-result overflow: big maxima over unit gradients
        send_point(FUNC_ACC, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, -1, 1);
        send_point(FUNC_FIN, 0, 0, 0, 0, 0, 0);
        send_point(FUNC_SCL, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_point(FUNC_SCL, 0, 0, 0, -1, 2, 0);
        // one zero gradient maximum among nonzero ones
        send_point(FUNC_ACC, 1000, 500, 2000, 0, 37, -12);
        send_point(FUNC_FIN, 0, 0, 0, 0, 0, 0);
        send_point(FUNC_SCL, 0, 0, 0, 5, -5, 32'h7FFF_FFFF);
        send_point(FUNC_ACC, 12345, 0, 1, -7, 0, 0);
        send_point(FUNC_FIN, 0, 0, 0, 0, 0, 0);
        send_point(FUNC_SCL, 0, 0, 0, -3, 3, 32'h8000_0000);

        // drain everything before the random phase
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        while (points_sent < POINTS) begin
            if ($urandom_range(0, 9) == 0)
                busy_sender = ~busy_sender;
            n = $urandom_range(1, 30);
            repeat (n) begin
                if ($urandom_range(0, 19) == 0)
                    send_random(FUNC_NOP);
                send_random(FUNC_ACC);
            end
            send_random(FUNC_FIN);
            n = $urandom_range(1, 20);
            repeat (n) send_random(($urandom_range(0, 14) == 0) ? FUNC_FIN : FUNC_SCL);
            if ($urandom_range(0, 29) == 0) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                repeat (60) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/gmrs_pkg.sv
rtl/gmrs_front.sv
rtl/gmrs_sqrt.sv
rtl/gmrs_div.sv
rtl/gmrs_back.sv
rtl/gradient_max_ratio_scaler_unit.sv
tb/gmrs_checker.sv
tb/tb_top.sv
